### design/rbst_pkg.sv
// Package for the ray/box slab test: constants, pipeline payload types.
`default_nettype none
package rbst_pkg;

	localparam int unsigned Q_W = 32;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_HIT_DISTANCE = 3'd0;

	// 33 quotient bits per division, 3 bits per pipeline stage
	localparam int unsigned DIV_STEPS = 33;
	localparam int unsigned DIV_BITS_PER_STAGE = 3;
	localparam int unsigned DIV_STAGES = DIV_STEPS / DIV_BITS_PER_STAGE;

	localparam int unsigned NUM_AXES = 3;
	localparam int unsigned NUM_SLABS = 2 * NUM_AXES;

	localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [Q_W-2:0] MAX_HIT_RESET = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [Q_W-1:0] rem;   // partial remainder
		logic [Q_W:0]   nq;    // numerator bits still to come, quotient bits shifted in
		logic [Q_W-1:0] dmag;  // divisor magnitude
		logic           neg;
		logic           ovf;   // quotient at least 2^33
	} slab_div_t;

	typedef struct packed {
		slab_div_t [NUM_SLABS-1:0] slab;
		logic [NUM_AXES-1:0]       dzero;
		logic [NUM_AXES-1:0]       in_slab;
	} div_pl_t;

endpackage
`default_nettype wire

### design/rbst_ifs.sv
// Valid/ready channel interfaces for ray items and hit results.
`default_nettype none
interface rbst_ray_if;
	logic        valid;
	logic        ready;
	logic [31:0] origin_x;
	logic [31:0] origin_y;
	logic [31:0] origin_z;
	logic [31:0] dir_x;
	logic [31:0] dir_y;
	logic [31:0] dir_z;
	logic [31:0] box_min_x;
	logic [31:0] box_min_y;
	logic [31:0] box_min_z;
	logic [31:0] box_max_x;
	logic [31:0] box_max_y;
	logic [31:0] box_max_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface rbst_hit_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] entry_distance;
	logic [31:0] exit_distance;

	modport source (output valid, hit, entry_distance, exit_distance, input ready);
	modport sink (input valid, hit, entry_distance, exit_distance, output ready);
endinterface
`default_nettype wire

### design/rbst_div_stage.sv
// One pipeline stage of the six parallel restoring dividers.
`default_nettype none
module rbst_div_stage #(
	parameter int unsigned STEPS = rbst_pkg::DIV_BITS_PER_STAGE
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire rbst_pkg::div_pl_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output rbst_pkg::div_pl_t    out_data
);

	logic              valid_q;
	rbst_pkg::div_pl_t data_q;
	rbst_pkg::div_pl_t next_data;

	always_comb begin
		logic [rbst_pkg::Q_W:0] trial;
		logic                   ge;
		next_data = in_data;
		for (int s = 0; s < rbst_pkg::NUM_SLABS; s++) begin
			for (int k = 0; k < STEPS; k++) begin
				trial = {next_data.slab[s].rem, next_data.slab[s].nq[rbst_pkg::Q_W]};
				ge = trial >= {1'b0, next_data.slab[s].dmag};
				if (ge) begin
					trial = trial - {1'b0, next_data.slab[s].dmag};
				end
				next_data.slab[s].rem = trial[rbst_pkg::Q_W-1:0];
				next_data.slab[s].nq = {next_data.slab[s].nq[rbst_pkg::Q_W-1:0], ge};
			end
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule
`default_nettype wire

### design/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test pipeline.
// Usage:
//   ray  : input channel, one ray (origin, direction) and box (min, max corners)
//          per transaction, all signed Q16.16.
//   res  : output channel, one result per ray: hit flag, entry and exit
//          distances (signed Q16.16, saturated).
//   APB  : register 0 at byte address 0 holds max_hit_distance (31 bits);
//          write it only while no transaction is in flight.
// From input transaction to result valid, an item passes one setup
// stage, 11 divider stages of 3 quotient bits each for the 33-bit quotient,
// then saturation, slab ordering, entry/exit reduction and the output stage.
// Throughput is one transaction per cycle while the receiver is ready; the six slab
// divisions run in parallel in their own pipelined restoring dividers.
// Reset empties the pipeline and sets max_hit_distance to 0x7FFFFFFF.
// When the receiver stalls, each stage holds its item and bubbles are
// squeezed out, so the input stays ready until the pipeline is full.
`default_nettype none
module ray_box_slab_test (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rbst_ray_if.sink         ray,
	rbst_hit_if.source       res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [rbst_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned W = rbst_pkg::Q_W;

	// configuration register
	logic [W-2:0] max_hit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hit_q <= rbst_pkg::MAX_HIT_RESET;
		end else if (psel && penable && pwrite && paddr == rbst_pkg::ADDR_MAX_HIT_DISTANCE) begin
			max_hit_q <= pwdata[W-2:0];
		end
	end

	assign prdata = (paddr == rbst_pkg::ADDR_MAX_HIT_DISTANCE) ? {1'b0, max_hit_q} : '0;

	// ready chain
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic              chain_valid [rbst_pkg::DIV_STAGES+1];
	logic              chain_ready [rbst_pkg::DIV_STAGES+1];
	rbst_pkg::div_pl_t chain_data  [rbst_pkg::DIV_STAGES+1];

	assign rdy_s5 = !valid_s5 || res.ready;
	assign rdy_s4 = !valid_s4 || rdy_s5;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign ray.ready = rdy_s1;

	// stage 1: differences, magnitudes, first remainder
	logic [W-1:0] org [rbst_pkg::NUM_AXES];
	logic [W-1:0] dir [rbst_pkg::NUM_AXES];
	logic [W-1:0] bmin [rbst_pkg::NUM_AXES];
	logic [W-1:0] bmax [rbst_pkg::NUM_AXES];
	rbst_pkg::div_pl_t prep;
	rbst_pkg::div_pl_t data_s1;

	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;
	assign bmin[0] = ray.box_min_x;
	assign bmin[1] = ray.box_min_y;
	assign bmin[2] = ray.box_min_z;
	assign bmax[0] = ray.box_max_x;
	assign bmax[1] = ray.box_max_y;
	assign bmax[2] = ray.box_max_z;

	always_comb begin
		logic [W-1:0] corner;
		logic [W:0]   diff;
		logic [W:0]   amag;
		logic [W-1:0] dmag;
		int unsigned  a;
		prep = '0;
		for (int s = 0; s < rbst_pkg::NUM_SLABS; s++) begin
			a = s % rbst_pkg::NUM_AXES;
			corner = (s < rbst_pkg::NUM_AXES) ? bmin[a] : bmax[a];
			diff = {corner[W-1], corner} - {org[a][W-1], org[a]};
			amag = diff[W] ? (~diff + 1'b1) : diff;
			dmag = dir[a][W-1] ? (~dir[a] + 1'b1) : dir[a];
			prep.slab[s].neg = diff[W] ^ dir[a][W-1];
			prep.slab[s].dmag = dmag;
			// numerator is amag << 16; top 16 bits seed the remainder
			prep.slab[s].rem = {16'b0, amag[W:17]};
			prep.slab[s].nq = {amag[16:0], 16'b0};
			prep.slab[s].ovf = {16'b0, amag[W:17]} >= dmag;
		end
		for (int x = 0; x < rbst_pkg::NUM_AXES; x++) begin
			prep.dzero[x] = dir[x] == '0;
			prep.in_slab[x] = ($signed(bmin[x]) <= $signed(org[x]))
				&& ($signed(org[x]) <= $signed(bmax[x]));
		end
	end

	assign rdy_s1 = !valid_s1 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= ray.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && ray.valid) begin
			data_s1 <= prep;
		end
	end

	// divider stages
	assign chain_valid[0] = valid_s1;
	assign chain_data[0] = data_s1;
	assign chain_ready[rbst_pkg::DIV_STAGES] = rdy_s2;

	for (genvar g = 0; g < rbst_pkg::DIV_STAGES; g++) begin : g_div
		rbst_div_stage #(
			.STEPS(rbst_pkg::DIV_BITS_PER_STAGE)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[g]),
			.in_ready (chain_ready[g]),
			.in_data  (chain_data[g]),
			.out_valid(chain_valid[g+1]),
			.out_ready(chain_ready[g+1]),
			.out_data (chain_data[g+1])
		);
	end

	rbst_pkg::div_pl_t div_out;
	assign div_out = chain_data[rbst_pkg::DIV_STAGES];

	// stage 2: sign and saturate quotients
	logic [W-1:0] tq_s2 [rbst_pkg::NUM_SLABS];
	logic [rbst_pkg::NUM_AXES-1:0] dzero_s2, in_slab_s2;
	logic [W-1:0] tq [rbst_pkg::NUM_SLABS];

	always_comb begin
		logic [W:0] q;
		for (int s = 0; s < rbst_pkg::NUM_SLABS; s++) begin
			q = div_out.slab[s].nq;
			if (div_out.slab[s].neg) begin
				if (div_out.slab[s].ovf || q > {2'b01, {(W-1){1'b0}}}) begin
					tq[s] = rbst_pkg::Q_MIN;
				end else begin
					tq[s] = ~q[W-1:0] + 1'b1;
				end
			end else begin
				if (div_out.slab[s].ovf || q[W:W-1] != 2'b00) begin
					tq[s] = rbst_pkg::Q_MAX;
				end else begin
					tq[s] = q[W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= chain_valid[rbst_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && chain_valid[rbst_pkg::DIV_STAGES]) begin
			tq_s2 <= tq;
			dzero_s2 <= div_out.dzero;
			in_slab_s2 <= div_out.in_slab;
		end
	end

	// stage 3: order each axis, handle zero direction
	logic [W-1:0] near_s3 [rbst_pkg::NUM_AXES];
	logic [W-1:0] far_s3 [rbst_pkg::NUM_AXES];
	logic [W-1:0] near_v [rbst_pkg::NUM_AXES];
	logic [W-1:0] far_v [rbst_pkg::NUM_AXES];

	always_comb begin
		logic [W-1:0] t1, t2;
		for (int x = 0; x < rbst_pkg::NUM_AXES; x++) begin
			t1 = tq_s2[x];
			t2 = tq_s2[x + rbst_pkg::NUM_AXES];
			if (dzero_s2[x]) begin
				near_v[x] = in_slab_s2[x] ? rbst_pkg::Q_MIN : rbst_pkg::Q_MAX;
				far_v[x] = in_slab_s2[x] ? rbst_pkg::Q_MAX : rbst_pkg::Q_MIN;
			end else if ($signed(t1) < $signed(t2)) begin
				near_v[x] = t1;
				far_v[x] = t2;
			end else begin
				near_v[x] = t2;
				far_v[x] = t1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			near_s3 <= near_v;
			far_s3 <= far_v;
		end
	end

	// stage 4: entry is the largest near, exit the smallest far
	logic [W-1:0] entry_s4, exit_s4;
	logic [W-1:0] entry_v, exit_v;

	always_comb begin
		entry_v = near_s3[0];
		exit_v = far_s3[0];
		for (int x = 1; x < rbst_pkg::NUM_AXES; x++) begin
			if ($signed(near_s3[x]) > $signed(entry_v)) begin
				entry_v = near_s3[x];
			end
			if ($signed(far_s3[x]) < $signed(exit_v)) begin
				exit_v = far_s3[x];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			entry_s4 <= entry_v;
			exit_s4 <= exit_v;
		end
	end

	// stage 5: hit decision, output register
	logic         hit_v;
	logic         hit_s5;
	logic [W-1:0] entry_s5, exit_s5;

	assign hit_v = !exit_s4[W-1]
		&& ($signed(entry_s4) <= $signed(exit_s4))
		&& (entry_s4[W-1] || entry_s4[W-2:0] <= max_hit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (rdy_s5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && valid_s4) begin
			hit_s5 <= hit_v;
			entry_s5 <= entry_s4;
			exit_s5 <= exit_s4;
		end
	end

	assign res.valid = valid_s5;
	assign res.hit = hit_s5;
	assign res.entry_distance = entry_s5;
	assign res.exit_distance = exit_s5;

endmodule
`default_nettype wire
